/* design/cs_pkg.sv */
// ----------------------------------------------------------------------------
// cs_pkg - contrast stretch shared constants
// Widths and reset values used across the contrast stretch block.
// ----------------------------------------------------------------------------
package cs_pkg;

  // grey levels on the ports and in the gain register
  localparam int GRAY_BITS = 16;

  // default number of pixel bits taken from each input word
  localparam int PIXEL_BITS_DEF = 16;

  // reset value of the max_gray register
  localparam logic [GRAY_BITS-1:0] MAX_GRAY_RST = 16'd255;

  // input command codes
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_APPLY   = 1'b1;

endpackage

/* design/cs_in_if.sv */
// ----------------------------------------------------------------------------
// cs_in_if - pixel input channel
// Valid/ready channel that carries one command word with its pixel.
// ----------------------------------------------------------------------------
interface cs_in_if
  import cs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [GRAY_BITS-1:0] pixel;
  logic                 last;

  modport source (output valid, output command, output pixel, output last, input ready);
  modport sink   (input valid, input command, input pixel, input last, output ready);
endinterface

/* design/cs_out_if.sv */
// ----------------------------------------------------------------------------
// cs_out_if - stretched pixel output channel
// Valid/ready channel that carries one stretched pixel word.
// ----------------------------------------------------------------------------
interface cs_out_if
  import cs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [GRAY_BITS-1:0] stretched_pixel;
  logic                 last_out;

  modport source (output valid, output stretched_pixel, output last_out, input ready);
  modport sink   (input valid, input stretched_pixel, input last_out, output ready);
endinterface

/* design/cs_range.sv */
// ----------------------------------------------------------------------------
// cs_range - frame range tracker
// Track running min/max over measure words and latch them on the last one.
// ----------------------------------------------------------------------------
module cs_range
  import cs_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  meas_en,
  input  logic                  meas_last,
  input  logic [PIXEL_BITS-1:0] meas_pixel,
  output logic [PIXEL_BITS-1:0] frame_min,
  output logic [PIXEL_BITS-1:0] frame_max
);

  logic [PIXEL_BITS-1:0] running_min;
  logic [PIXEL_BITS-1:0] running_max;
  logic [PIXEL_BITS-1:0] min_next;
  logic [PIXEL_BITS-1:0] max_next;

  assign min_next = (meas_pixel < running_min) ? meas_pixel : running_min;
  assign max_next = (meas_pixel > running_max) ? meas_pixel : running_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= '1;
      running_max <= '0;
      frame_min   <= '0;
      frame_max   <= '0;
    end else if (meas_en) begin
      if (meas_last) begin
        // latch the frame range, restart tracking
        frame_min   <= min_next;
        frame_max   <= max_next;
        running_min <= '1;
        running_max <= '0;
      end else begin
        running_min <= min_next;
        running_max <= max_next;
      end
    end
  end

endmodule

/* design/cs_mul_div.sv */
// ----------------------------------------------------------------------------
// cs_mul_div - bit-serial scale and divide
// Shift-add multiply d*g, then restoring divide by s, one bit per cycle.
// ----------------------------------------------------------------------------
module cs_mul_div
  import cs_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PIXEL_BITS-1:0] d,
  input  logic [PIXEL_BITS-1:0] s,
  input  logic [GRAY_BITS-1:0]  g,
  output logic                  done,
  output logic [GRAY_BITS-1:0]  q
);

  localparam int STEPS = GRAY_BITS;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  typedef enum logic [1:0] {
    P_IDLE,
    P_MUL,
    P_DIV
  } phase_t;

  phase_t                phase;
  logic [CNT_W-1:0]      cnt;
  logic [PIXEL_BITS-1:0] d_r;
  logic [PIXEL_BITS-1:0] s_r;
  logic [PIXEL_BITS-1:0] hi;
  logic [GRAY_BITS-1:0]  lo;

  logic [PIXEL_BITS:0]   add_sum;
  logic [PIXEL_BITS:0]   rem_trial;
  logic [PIXEL_BITS:0]   rem_diff;
  logic                  rem_ge;

  assign add_sum   = {1'b0, hi} + (lo[0] ? {1'b0, d_r} : '0);
  assign rem_trial = {hi, lo[GRAY_BITS-1]};
  assign rem_diff  = rem_trial - {1'b0, s_r};
  assign rem_ge    = (rem_trial >= {1'b0, s_r});
  assign q         = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            d_r   <= d;
            s_r   <= s;
            hi    <= '0;
            lo    <= g;
            cnt   <= '0;
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          // add multiplicand on a set multiplier bit, shift product right
          hi  <= add_sum[PIXEL_BITS:1];
          lo  <= {add_sum[0], lo[GRAY_BITS-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          // trial subtract, shift quotient bit in from the right
          hi  <= rem_ge ? rem_diff[PIXEL_BITS-1:0] : rem_trial[PIXEL_BITS-1:0];
          lo  <= {lo[GRAY_BITS-2:0], rem_ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            done  <= 1'b1;
            phase <= P_IDLE;
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/contrast_stretch_unit.sv */
// ----------------------------------------------------------------------------
// contrast_stretch_unit - linear contrast stretch, two passes per frame
// Measure words collect the frame range, apply words are scaled to 0..max_gray.
// Flow: an apply word passes setup, the bit-serial shift-add multiply and
//   restoring divide, collect and load before its result is valid, or it is
//   settled in setup when the range is flat or saturation applies.
// Throughput: no new word is taken while an apply word is in flight, and the
//   load step waits while the output register stays full; one measure word
//   per cycle while no apply word is in flight.
// Reset: synchronous active high; max_gray returns to 255, the frame range to
//   0..0 (flat, so apply words give 0) and the running range is emptied.
// ----------------------------------------------------------------------------
module contrast_stretch_unit
  import cs_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [GRAY_BITS-1:0] cfg_wdata,
  cs_in_if.sink                pixels,
  cs_out_if.source             stretched
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_LOAD
  } state_t;

  state_t                state;
  logic [GRAY_BITS-1:0]  max_gray;

  // captured apply word
  logic [PIXEL_BITS-1:0] pix;
  logic                  pix_last;

  // result waiting for the output register
  logic [GRAY_BITS-1:0]  result;

  // output register
  logic                  out_valid;
  logic [GRAY_BITS-1:0]  out_pixel;
  logic                  out_last;

  logic [PIXEL_BITS-1:0] frame_min;
  logic [PIXEL_BITS-1:0] frame_max;
  logic [PIXEL_BITS-1:0] in_pixel;
  logic                  accept;
  logic                  meas_en;

  logic                  range_flat;
  logic                  below_min;
  logic                  above_max;
  logic [PIXEL_BITS-1:0] span;
  logic [PIXEL_BITS-1:0] offset;
  logic                  md_start;
  logic                  md_done;
  logic [GRAY_BITS-1:0]  md_q;
  logic                  out_free;

  // only the low pixel bits take part
  assign in_pixel = pixels.pixel[PIXEL_BITS-1:0];

  // take a word only while no apply word is in flight
  assign pixels.ready = (state == S_IDLE);
  assign accept       = pixels.valid && pixels.ready;
  assign meas_en      = accept && (pixels.command == CMD_MEASURE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gray <= MAX_GRAY_RST;
    end else if (cfg_we) begin
      max_gray <= cfg_wdata;
    end
  end

  cs_range #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_range (
    .clk        (clk),
    .rst        (rst),
    .meas_en    (meas_en),
    .meas_last  (pixels.last),
    .meas_pixel (in_pixel),
    .frame_min  (frame_min),
    .frame_max  (frame_max)
  );

  // Special cases settle in the setup cycle: a flat range or a pixel at or
  // below the minimum gives 0; a pixel at or above the maximum saturates to
  // max_gray. Everything else has offset < span, so the quotient stays below
  // max_gray (or is 0 when max_gray is 0) and fits the 16-bit shift register.
  assign range_flat = (frame_max <= frame_min);
  assign below_min  = (pix <= frame_min);
  assign above_max  = (pix >= frame_max);
  assign span       = frame_max - frame_min;
  assign offset     = pix - frame_min;
  assign md_start   = (state == S_SETUP) && !range_flat && !below_min && !above_max;

  cs_mul_div #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mul_div (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .d     (offset),
    .s     (span),
    .g     (max_gray),
    .done  (md_done),
    .q     (md_q)
  );

  // output register frees up in the same cycle its word is taken
  assign out_free = !out_valid || stretched.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && stretched.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // hold apply words, measure words finish in the range tracker
          if (accept && (pixels.command == CMD_APPLY)) begin
            pix      <= in_pixel;
            pix_last <= pixels.last;
            state    <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (range_flat || below_min) begin
            result <= '0;
            state  <= S_LOAD;
          end else if (above_max) begin
            result <= max_gray;
            state  <= S_LOAD;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          // wait for the serial multiply and divide to drain
          if (md_done) begin
            result <= md_q;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          // advance into the output register once it is free
          if (out_free) begin
            out_valid <= 1'b1;
            out_pixel <= result;
            out_last  <= pix_last;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stretched.valid           = out_valid;
  assign stretched.stretched_pixel = out_pixel;
  assign stretched.last_out        = out_last;

endmodule

/* sim/stretch_checker.sv */
// ----------------------------------------------------------------------------
// stretch_checker - contrast stretch predictor and result comparator
// Watches both channels and the max_gray write port. It keeps its own copy of
// the frame range and predicts each stretched word. Each result is compared
// against the oldest prediction, and counts go back to the testbench.
// ----------------------------------------------------------------------------
module stretch_checker
  import cs_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [GRAY_BITS-1:0] cfg_wdata,
  cs_in_if                     pixels,
  cs_out_if                    stretched,
  output int                   fail_count,
  output int                   pending,
  output int                   measure_count,
  output int                   apply_count,
  output int                   result_count
);

  localparam logic [GRAY_BITS-1:0] PIX_MASK = GRAY_BITS'((32'd1 << PIXEL_BITS) - 32'd1);

  typedef struct packed {
    logic [GRAY_BITS-1:0] level;
    logic                 tail;
  } stretch_word_t;

  stretch_word_t        expected_q[$];
  logic [GRAY_BITS-1:0] gain;
  logic [GRAY_BITS-1:0] run_lo, run_hi;
  logic [GRAY_BITS-1:0] frame_lo, frame_hi;
  int                   mismatches = 0;
  int                   n_measure = 0, n_apply = 0, n_result = 0;

  initial begin
    fail_count    = 0;
    pending       = 0;
    measure_count = 0;
    apply_count   = 0;
    result_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] stretch mismatch: %s", $time, msg);
  endtask

  // (level - min) * gain / (max - min), floored and clamped to gain
  function automatic logic [GRAY_BITS-1:0] scale_level(input logic [GRAY_BITS-1:0] lvl);
    logic [31:0] span, num, quo;
    if (frame_hi <= frame_lo || lvl <= frame_lo)
      return '0;
    span = 32'(frame_hi - frame_lo);
    num  = 32'(lvl - frame_lo) * 32'(gain);
    quo  = num / span;
    if (quo > 32'(gain))
      quo = 32'(gain);
    return quo[GRAY_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    stretch_word_t        want;
    logic [GRAY_BITS-1:0] lvl;
    if (rst) begin
      gain     = MAX_GRAY_RST;
      run_lo   = PIX_MASK;
      run_hi   = '0;
      frame_lo = '0;
      frame_hi = '0;
      expected_q.delete();
    end else begin
      if (cfg_we)
        gain = cfg_wdata;

      // check the result first: it can never belong to a word taken this edge
      if (stretched.valid && stretched.ready) begin
        n_result++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("word %0d/%0b arrived with nothing expected",
                                    stretched.stretched_pixel, stretched.last_out));
        end else begin
          want = expected_q.pop_front();
          if (stretched.stretched_pixel !== want.level)
            report_mismatch($sformatf("stretched_pixel expected %0d, got %0d",
                                      want.level, stretched.stretched_pixel));
          if (stretched.last_out !== want.tail)
            report_mismatch($sformatf("last_out expected %0b, got %0b",
                                      want.tail, stretched.last_out));
        end
      end

      if (pixels.valid && pixels.ready) begin
        lvl = pixels.pixel & PIX_MASK;
        if (pixels.command == CMD_MEASURE) begin
          n_measure++;
          if (lvl < run_lo) run_lo = lvl;
          if (lvl > run_hi) run_hi = lvl;
          if (pixels.last) begin
            frame_lo = run_lo;
            frame_hi = run_hi;
            run_lo   = PIX_MASK;
            run_hi   = '0;
          end
        end else begin
          n_apply++;
          want.level = scale_level(lvl);
          want.tail  = pixels.last;
          expected_q.push_back(want);
        end
      end
    end
    fail_count    <= mismatches;
    pending       <= expected_q.size();
    measure_count <= n_measure;
    apply_count   <= n_apply;
    result_count  <= n_result;
  end

endmodule

/* sim/tb_contrast_stretch_unit.sv */
// ----------------------------------------------------------------------------
// tb_contrast_stretch_unit - contrast stretch unit testbench
// Drives measure and apply words through the pixel channel with random gaps
// and random back-pressure on the result channel, and walks max_gray through
// several settings. A directed opening hits the range corners; random frames
// with broken passes and noise words follow. The checker predicts and counts.
// ----------------------------------------------------------------------------
module tb_contrast_stretch_unit;
  import cs_pkg::*;

  // no word moving for this many cycles means the block is hung
  localparam int STUCK_LIMIT   = 1000;
  // give the block a margin past the apply latency
  localparam int SETTLE_CYCLES = 50;
  // random words per max_gray setting
  localparam int PHASE_WORDS   = 58;
  localparam int PHASES        = 6;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [GRAY_BITS-1:0] cfg_wdata;

  cs_in_if  pix_ch();
  cs_out_if out_ch();

  int fails, pending, n_measure, n_apply, n_result;
  int words_sent = 0;
  int gain_writes = 0;
  bit tx_calm = 1'b0;   // sender runs back to back while set

  contrast_stretch_unit #(
    .PIXEL_BITS(PIXEL_BITS_DEF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .pixels   (pix_ch),
    .stretched(out_ch)
  );

  stretch_checker #(
    .PIXEL_BITS(PIXEL_BITS_DEF)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .pixels       (pix_ch),
    .stretched    (out_ch),
    .fail_count   (fails),
    .pending      (pending),
    .measure_count(n_measure),
    .apply_count  (n_apply),
    .result_count (n_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly from the short band, sometimes the middle band, rarely long.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Result side back-pressure. Work in segments: some segments hold ready
  // high throughout, the rest drop it at random for random stretches.
  initial begin : result_sink
    int  hold, seg;
    bit  rx_calm;
    out_ch.ready <= 1'b0;
    hold    = 0;
    seg     = 0;
    rx_calm = 1'b0;
    forever begin
      @(posedge clk);
      if (seg == 0) begin
        seg     = $urandom_range(50, 200);
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      seg--;
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        hold = pause_len() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one word and hold it until the block takes it. Valid stays high on
  // return so that a back-to-back word needs no second assignment this step.
  task automatic send_word(input logic cmd, input logic [GRAY_BITS-1:0] lvl,
                           input logic tail);
    int idle;
    idle = 0;
    if (!tx_calm && $urandom_range(0, 2) == 0)
      idle = pause_len();
    if (idle > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    pix_ch.valid   <= 1'b1;
    pix_ch.command <= cmd;
    pix_ch.pixel   <= lvl;
    pix_ch.last    <= tail;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid, wait for every predicted word to come back, then give the
  // block time to finish any measure word still in flight.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GRAY_BITS-1:0] g);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gain_writes++;
  endtask

  // One frame: a measure pass over a chosen pixel band, then an apply pass
  // that lands mostly inside the band and sometimes outside it. Now and then
  // drop the closing last so the range spills into the next frame, and mix
  // in noise words with random fields.
  task automatic run_frame();
    int   n_meas, n_app, lo, hi, span, v;
    logic tail;
    tx_calm = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: begin
        lo = 0;
        hi = 65535;
      end
      1: begin
        span = $urandom_range(1, 64);
        lo   = $urandom_range(0, 65535 - span);
        hi   = lo + span;
      end
      2: begin
        lo = $urandom_range(0, 65535);
        hi = lo;
      end
      default: begin
        span = $urandom_range(256, 20000);
        lo   = $urandom_range(0, 65535 - span);
        hi   = lo + span;
      end
    endcase
    n_meas = $urandom_range(1, 12);
    n_app  = $urandom_range(1, 12);

    for (int i = 0; i < n_meas; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_word(1'($urandom_range(0, 1)), 16'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        tail = (i == n_meas - 1) && ($urandom_range(0, 9) != 0);
        send_word(CMD_MEASURE, 16'($urandom_range(lo, hi)), tail);
      end
    end

    for (int i = 0; i < n_app; i++) begin
      case ($urandom_range(0, 9))
        0: v = $urandom_range(0, 65535);
        1: begin
          v = lo - int'($urandom_range(1, 300));
          if (v < 0) v = 0;
        end
        2: begin
          v = hi + int'($urandom_range(1, 300));
          if (v > 65535) v = 65535;
        end
        3: v = lo;
        4: v = hi;
        default: v = $urandom_range(lo, hi);
      endcase
      send_word(CMD_APPLY, 16'(v), i == n_app - 1);
    end
  endtask

  // Hang detector: count cycles in which neither channel moves a word.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((pix_ch.valid && pix_ch.ready) || (out_ch.valid && out_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [GRAY_BITS-1:0] g;
    int                   phase_start;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    pix_ch.valid   <= 1'b0;
    pix_ch.command <= CMD_MEASURE;
    pix_ch.pixel   <= '0;
    pix_ch.last    <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed part, max_gray at its reset value ---
    tx_calm = 1'b1;
    // apply before any measure pass: reset range is flat, expect zeros
    send_word(CMD_APPLY, 16'h0000, 1'b0);
    send_word(CMD_APPLY, 16'hFFFF, 1'b1);
    // full-scale frame, then apply at both ends and the middle
    send_word(CMD_MEASURE, 16'h0000, 1'b0);
    send_word(CMD_MEASURE, 16'hFFFF, 1'b0);
    send_word(CMD_MEASURE, 16'hAAAA, 1'b1);
    send_word(CMD_APPLY, 16'h0000, 1'b0);
    send_word(CMD_APPLY, 16'hFFFF, 1'b0);
    send_word(CMD_APPLY, 16'h5555, 1'b1);
    // narrow frame 100..200: below, at min, inside, at max, above
    tx_calm = 1'b0;
    send_word(CMD_MEASURE, 16'd100, 1'b0);
    send_word(CMD_MEASURE, 16'd200, 1'b1);
    send_word(CMD_APPLY, 16'd50, 1'b0);
    send_word(CMD_APPLY, 16'd100, 1'b0);
    send_word(CMD_APPLY, 16'd150, 1'b0);
    // last on an apply word must leave the range alone
    send_word(CMD_APPLY, 16'd200, 1'b1);
    send_word(CMD_APPLY, 16'd300, 1'b0);
    send_word(CMD_APPLY, 16'hFFFF, 1'b1);
    // single-word frame: flat range again
    send_word(CMD_MEASURE, 16'd500, 1'b1);
    send_word(CMD_APPLY, 16'd500, 1'b0);
    send_word(CMD_APPLY, 16'd600, 1'b1);

    // top gain with an alternating-bit frame; products reach full width
    settle();
    write_gain(16'hFFFF);
    send_word(CMD_MEASURE, 16'h5555, 1'b0);
    send_word(CMD_MEASURE, 16'hAAAA, 1'b1);
    send_word(CMD_APPLY, 16'h5555, 1'b0);
    send_word(CMD_APPLY, 16'hAAAA, 1'b0);
    send_word(CMD_APPLY, 16'h8000, 1'b1);

    // zero gain: every stretched word is zero
    settle();
    write_gain('0);
    send_word(CMD_APPLY, 16'hAAAA, 1'b0);
    send_word(CMD_APPLY, 16'h8000, 1'b1);

    // --- random frames, one max_gray setting per phase ---
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       g = 16'd1;
        1:       g = 16'hFFFF;
        2:       g = 16'($urandom_range(2, 65534));
        3:       g = MAX_GRAY_RST;
        4:       g = '0;
        default: g = 16'($urandom_range(1, 16));
      endcase
      // the block must be idle before the register changes
      settle();
      write_gain(g);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS)
        run_frame();
    end

    // drain, then let the block sit so a stray word would still be seen
    settle();

    $display("Sent %0d measure and %0d apply words across %0d max_gray settings;",
             n_measure, n_apply, gain_writes + 1);
    $display("compared %0d stretched words under random gaps and back-pressure.",
             n_result);
    if (fails == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
